>>> src/arlb_pkg.sv
// Shared types and constants for the activity rate LED blinker.
// Used by arlb_csr, arlb_div and activity_rate_led_blinker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package arlb_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int TIME_BITS_DEF  = 32;
   localparam int DIV_BITS_DEF   = 32;

   localparam int PER_SEC_BITS = 10;
   localparam logic [PER_SEC_BITS-1:0] PER_SEC = 10'd1000;

   localparam int CFG_BITS  = 16;
   localparam int DATA_BITS = 32;
   localparam int ADDR_BITS = 4;

   localparam logic [1:0] REG_WINDOW_MS    = 2'd0;
   localparam logic [1:0] REG_BLINK_MIN_MS = 2'd1;
   localparam logic [1:0] REG_BLINK_MAX_MS = 2'd2;

   localparam logic [CFG_BITS-1:0] WINDOW_MS_RST    = 16'd3000;
   localparam logic [CFG_BITS-1:0] BLINK_MIN_MS_RST = 16'd80;
   localparam logic [CFG_BITS-1:0] BLINK_MAX_MS_RST = 16'd600;

   typedef struct packed {
      logic [CFG_BITS-1:0] window_ms;
      logic [CFG_BITS-1:0] blink_min_ms;
      logic [CFG_BITS-1:0] blink_max_ms;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

>>> src/arlb_csr.sv
// Configuration registers of the LED blinker behind an APB-style port.
// Depends on arlb_pkg for the register map, reset values and cfg_type.
`timescale 1ns / 1ps
`default_nettype none
module arlb_csr
   import arlb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [DATA_BITS-1:0] pwdata,
   output logic      [DATA_BITS-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_WINDOW_MS:    cfg_in.window_ms    = pwdata[CFG_BITS-1:0];
            REG_BLINK_MIN_MS: cfg_in.blink_min_ms = pwdata[CFG_BITS-1:0];
            REG_BLINK_MAX_MS: cfg_in.blink_max_ms = pwdata[CFG_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_WINDOW_MS:    prdata = DATA_BITS'(cfg_ff.window_ms);
         REG_BLINK_MIN_MS: prdata = DATA_BITS'(cfg_ff.blink_min_ms);
         REG_BLINK_MAX_MS: prdata = DATA_BITS'(cfg_ff.blink_max_ms);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms    <= WINDOW_MS_RST;
         cfg_ff.blink_min_ms <= BLINK_MIN_MS_RST;
         cfg_ff.blink_max_ms <= BLINK_MAX_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

>>> src/arlb_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, shared by both
// divisions of a status tick. Depends on arlb_pkg for div_status_type.
`timescale 1ns / 1ps
`default_nettype none
module arlb_div
   import arlb_pkg::*;
#(
   parameter int DIV_BITS = DIV_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DIV_BITS-1:0] dividend,
   input  wire logic [DIV_BITS-1:0] divisor,
   output logic      [DIV_BITS-1:0] quotient,
   output div_status_type           status
);

   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIV_BITS:0]   rem_sh;
   logic [DIV_BITS:0]   diff;
   logic                ge;

   assign rem_sh = {rem_ff, quo_ff[DIV_BITS-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_BITS'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], ge};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

>>> src/activity_rate_led_blinker.sv
// Top level of the activity rate LED blinker: sequencer, blink state, result register.
// Depends on arlb_pkg, arlb_csr and arlb_div.
// An activity request, a tick while stopped, and a tick with no recent activity pass from
// ST_CHECK straight to ST_DONE; a tick in the same millisecond as the window start also
// passes through ST_CMP. A tick that must work out the blink interval runs two divisions
// on the shared bit-serial divider, one quotient bit per cycle, in ST_DIV1 and ST_DIV2
// before ST_CMP, or only the first when the event rate comes out as zero. DIV_BITS is the
// larger of COUNT_BITS+10 and TIME_BITS.
// One request is in work at a time; the next one is accepted the cycle after the result
// is loaded, even while that result waits on the result register. A stalled result
// delays only the loading of the one after it.
`timescale 1ns / 1ps
`default_nettype none
module activity_rate_led_blinker
   import arlb_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_action,
   input  wire logic [31:0]          req_time_ms,
   input  wire logic                 req_running,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_green_lamp,
   output logic                      rsp_red_led,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [DATA_BITS-1:0] pwdata,
   output logic      [DATA_BITS-1:0] prdata,
   output logic                      pready
);

   localparam int NUM_BITS = COUNT_BITS + PER_SEC_BITS;
   localparam int DIV_BITS = (NUM_BITS > TIME_BITS) ? NUM_BITS : TIME_BITS;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_DIV1  = 6'b000100,
      ST_DIV2  = 6'b001000,
      ST_CMP   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   cfg_type        cfg;
   div_status_type div_status;
   logic           div_start;
   logic [DIV_BITS-1:0] div_dividend, div_divisor, div_quo;

   state_type state_ff, state_in;

   logic                  act_ff, run_ff;
   logic [TIME_BITS-1:0]  now_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TIME_BITS-1:0]  win_start_ff, win_start_in;
   logic [TIME_BITS-1:0]  last_toggle_ff, last_toggle_in;
   logic                  phase_ff, phase_in;
   logic                  green_ff, green_in;
   logic                  red_ff, red_in;
   logic [CFG_BITS-1:0]   interval_ff, interval_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_green_ff, rsp_red_ff;
   logic                  rsp_load;

   logic                  req_take;
   logic [TIME_BITS-1:0]  since_ws;
   logic [TIME_BITS-1:0]  since_lt;
   logic                  expired;
   logic [NUM_BITS-1:0]   numer;
   logic [DIV_BITS-1:0]   iv_lo;
   logic [DIV_BITS-1:0]   iv_hi;

   arlb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   arlb_div #(
      .DIV_BITS (DIV_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .status   (div_status)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign since_ws = now_ff - win_start_ff;
   assign since_lt = now_ff - last_toggle_ff;
   assign expired  = since_ws > TIME_BITS'(cfg.window_ms);
   assign numer    = NUM_BITS'(count_ff) * NUM_BITS'(PER_SEC);

   assign iv_lo = (div_quo < DIV_BITS'(cfg.blink_min_ms)) ? DIV_BITS'(cfg.blink_min_ms)
                                                           : div_quo;
   assign iv_hi = (iv_lo > DIV_BITS'(cfg.blink_max_ms)) ? DIV_BITS'(cfg.blink_max_ms)
                                                        : iv_lo;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      win_start_in   = win_start_ff;
      last_toggle_in = last_toggle_ff;
      phase_in       = phase_ff;
      green_in       = green_ff;
      red_in         = red_ff;
      interval_in    = interval_ff;
      div_start      = 1'b0;
      div_dividend   = DIV_BITS'(numer);
      div_divisor    = DIV_BITS'(since_ws);
      rsp_load       = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_DONE;
            if (act_ff) begin
               if (expired) begin
                  win_start_in = now_ff;
                  count_in     = '0;
                  if (COUNT_BITS > 0) begin
                     count_in = COUNT_BITS'(1);
                  end
               end else if (count_ff != '1) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
            end else if (!run_ff) begin
               green_in = 1'b0;
               red_in   = 1'b1;
               phase_in = 1'b0;
            end else begin
               red_in = 1'b0;
               if (count_ff == '0 || expired) begin
                  count_in = '0;
                  phase_in = 1'b1;
                  green_in = 1'b1;
               end else if (since_ws == '0) begin
                  interval_in = cfg.blink_max_ms;
                  state_in    = ST_CMP;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV1;
               end
            end
         end
         ST_DIV1: begin
            div_dividend = DIV_BITS'(PER_SEC);
            div_divisor  = div_quo;
            if (div_status.done) begin
               if (div_quo == '0) begin
                  interval_in = cfg.blink_max_ms;
                  state_in    = ST_CMP;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV2;
               end
            end
         end
         ST_DIV2: begin
            if (div_status.done) begin
               interval_in = iv_hi[CFG_BITS-1:0];
               state_in    = ST_CMP;
            end
         end
         ST_CMP: begin
            if (since_lt >= TIME_BITS'(interval_ff)) begin
               phase_in       = !phase_ff;
               green_in       = !phase_ff;
               last_toggle_in = now_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff <= req_action;
         now_ff <= TIME_BITS'(req_time_ms);
         run_ff <= req_running;
      end
      if (rsp_load) begin
         rsp_green_ff <= green_ff;
         rsp_red_ff   <= red_ff;
      end
      interval_ff <= interval_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         win_start_ff   <= '0;
         last_toggle_ff <= '0;
         phase_ff       <= 1'b0;
         green_ff       <= 1'b0;
         red_ff         <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         win_start_ff   <= win_start_in;
         last_toggle_ff <= last_toggle_in;
         phase_ff       <= phase_in;
         green_ff       <= green_in;
         red_ff         <= red_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_green_lamp = rsp_green_ff;
   assign rsp_red_led    = rsp_red_ff;

   a_take_enters_check: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_CHECK)
      else $error("accepted request did not start evaluation");

   a_div_done_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV1 || state_ff == ST_DIV2))
      else $error("divider finished outside a division step");

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

   a_red_excludes_green: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_red_led |-> !rsp_green_lamp)
      else $error("red and green lit together");

endmodule
`default_nettype wire
